// File: src/morse_run_length_decoder_defines.svh
// Assertion macros shared by the Morse run-length decoder RTL.
`ifndef MORSE_RUN_LENGTH_DECODER_DEFINES_SVH
`define MORSE_RUN_LENGTH_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked on every clock edge outside reset.
`define MRLD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("mrld assertion failed");

// Same-cycle implication checked outside reset.
`define MRLD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mrld implication failed");

`else

`define MRLD_ASSERT(lbl, prop)
`define MRLD_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

// File: src/mrld_pkg.sv
// Shared types, constants and the letter table of the Morse run-length decoder.
`timescale 1ns / 1ps

package mrld_pkg;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		CFG_DASH_LENGTH = 2'd0,
		CFG_LETTER_GAP  = 2'd1,
		CFG_WORD_GAP    = 2'd2
	} cfg_index_t;

	localparam logic [3:0] DASH_LENGTH_RST = 4'd3;
	localparam logic [3:0] LETTER_GAP_RST  = 4'd3;
	localparam logic [3:0] WORD_GAP_RST    = 4'd7;

	localparam logic [3:0] RUN_MAX       = 4'd15;
	localparam int         TABLE_SYMBOLS = 4;
	localparam int         MAX_RESULTS   = 3;

	localparam logic [6:0] CHAR_SPACE   = 7'd32;
	localparam logic [6:0] CHAR_NEWLINE = 7'd10;

	typedef struct packed {
		logic [3:0] dash_length;
		logic [3:0] letter_gap_length;
		logic [3:0] word_gap_length;
	} cfg_t;

	// Up to three characters produced by one sample
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][6:0] codes;
	} bundle_t;

	// Letters indexed by (2^len - 2) + pattern, dash = 1, first symbol is MSB
	localparam logic [6:0] LETTER_TABLE [32] = '{
		7'd69, 7'd84,                                  // E T
		7'd73, 7'd65, 7'd78, 7'd77,                    // I A N M
		7'd83, 7'd85, 7'd82, 7'd87,                    // S U R W
		7'd68, 7'd75, 7'd71, 7'd79,                    // D K G O
		7'd72, 7'd86, 7'd70, 7'd0,                     // H V F -
		7'd76, 7'd0,  7'd80, 7'd74,                    // L - P J
		7'd66, 7'd88, 7'd67, 7'd89,                    // B X C Y
		7'd90, 7'd81, 7'd0,  7'd0,                     // Z Q - -
		7'd0,  7'd0
	};

	// Table lookup for a code of 1 to 4 symbols
	function automatic logic [6:0] letter_lookup(logic [2:0] len, logic [3:0] pat);
		logic [4:0] base;
		logic [3:0] mask;
		logic [4:0] idx;
		base = (5'd1 << len) - 5'd2;
		mask = 4'((5'd1 << len) - 5'd1);
		idx  = base + {1'b0, pat & mask};
		return LETTER_TABLE[idx];
	endfunction

endpackage

// File: src/mrld_front.sv
// Front end: takes samples, tracks runs and the pending code, builds result bundles.
`timescale 1ns / 1ps
`include "morse_run_length_decoder_defines.svh"

module mrld_front #(
	parameter int MAX_CODE_SYMBOLS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  logic             sample_level,
	input  logic             line_end,
	input  mrld_pkg::cfg_t   cfg,
	input  logic             q_full,
	output logic             push,
	output mrld_pkg::bundle_t bundle
);
	import mrld_pkg::*;

	localparam int PW = MAX_CODE_SYMBOLS;
	localparam int LW = $clog2(MAX_CODE_SYMBOLS + 2);
	localparam logic [LW-1:0] LEN_MAX   = LW'(MAX_CODE_SYMBOLS);
	localparam logic [LW-1:0] LEN_OVER  = LW'(MAX_CODE_SYMBOLS + 1);
	localparam logic [LW-1:0] LEN_TABLE = LW'(TABLE_SYMBOLS);

	typedef struct packed {
		logic [PW-1:0] pat;
		logic [LW-1:0] len;
		logic [1:0]    ne;
		logic [6:0]    c0;
		logic [6:0]    c1;
	} close_t;

	logic          prev_level_q, prev_level_d;
	logic [3:0]    run_count_q, run_count_d;
	logic          run_is_gap_q, run_is_gap_d;
	logic          line_started_q, line_started_d;
	logic [PW-1:0] code_pattern_q, code_pattern_d;
	logic [LW-1:0] code_length_q, code_length_d;
	logic [1:0]    n;
	logic [2:0][6:0] codes;
	logic [2:0]    need;
	close_t        cr;
	logic          accept;

	// Empty or over-long codes give 0
	function automatic logic [6:0] lookup_code(logic [PW-1:0] pat, logic [LW-1:0] len);
		if (len == '0 || len > LEN_TABLE) begin
			return 7'd0;
		end
		return letter_lookup(3'(len), pat[3:0]);
	endfunction

	// Ends the current run: a mark adds a symbol, a matching gap emits
	function automatic close_t close_run(logic gap, logic [3:0] cnt, logic [PW-1:0] pat,
			logic [LW-1:0] len, cfg_t c);
		close_t r;
		r.pat = pat;
		r.len = len;
		r.ne  = 2'd0;
		r.c0  = 7'd0;
		r.c1  = 7'd0;
		if (!gap) begin
			if (len < LEN_MAX) begin
				r.pat = {pat[PW-2:0], cnt == c.dash_length};
				r.len = len + LW'(1);
			end else begin
				r.len = LEN_OVER;
			end
		end else if (cnt == c.word_gap_length) begin
			r.ne  = 2'd2;
			r.c0  = lookup_code(pat, len);
			r.c1  = CHAR_SPACE;
			r.pat = '0;
			r.len = '0;
		end else if (cnt == c.letter_gap_length) begin
			r.ne  = 2'd1;
			r.c0  = lookup_code(pat, len);
			r.pat = '0;
			r.len = '0;
		end
		return r;
	endfunction

	assign sample_stall = q_full;
	assign accept       = sample_valid && !sample_stall;

	// Next state and the characters caused by this sample
	always_comb begin
		prev_level_d   = prev_level_q;
		run_count_d    = run_count_q;
		run_is_gap_d   = run_is_gap_q;
		line_started_d = line_started_q;
		code_pattern_d = code_pattern_q;
		code_length_d  = code_length_q;
		n     = 2'd0;
		codes = '0;
		need  = 3'd0;
		cr    = '0;

		if (!line_started_q) begin
			line_started_d = 1'b1;
			prev_level_d   = sample_level;
			run_count_d    = 4'd1;
			run_is_gap_d   = 1'b0;
		end else if (sample_level == prev_level_q) begin
			if (run_count_q != RUN_MAX) begin
				run_count_d = run_count_q + 4'd1;
			end
		end else begin
			cr = close_run(run_is_gap_q, run_count_q, code_pattern_q, code_length_q, cfg);
			code_pattern_d = cr.pat;
			code_length_d  = cr.len;
			if (cr.ne != 2'd0 && n != 2'd3) begin
				codes[n] = cr.c0;
				n = n + 2'd1;
			end
			if (cr.ne == 2'd2 && n != 2'd3) begin
				codes[n] = cr.c1;
				n = n + 2'd1;
			end
			run_is_gap_d = !run_is_gap_q;
			run_count_d  = 4'd1;
			prev_level_d = sample_level;
		end

		// Line end: close the final run, flush the letter, add a newline
		if (line_end) begin
			cr = close_run(run_is_gap_d, run_count_d, code_pattern_d, code_length_d, cfg);
			code_pattern_d = cr.pat;
			code_length_d  = cr.len;
			if (cr.ne != 2'd0 && n != 2'd3) begin
				codes[n] = cr.c0;
				n = n + 2'd1;
			end
			if (cr.ne == 2'd2 && n != 2'd3) begin
				codes[n] = cr.c1;
				n = n + 2'd1;
			end
			need = (code_length_d != '0) ? 3'd2 : 3'd1;
			// crowded line end drops the space
			if ({1'b0, n} + need > 3'(MAX_RESULTS)) begin
				n = 2'd1;
			end
			if (code_length_d != '0 && n != 2'd3) begin
				codes[n] = lookup_code(code_pattern_d, code_length_d);
				n = n + 2'd1;
			end
			if (n != 2'd3) begin
				codes[n] = CHAR_NEWLINE;
				n = n + 2'd1;
			end
			code_pattern_d = '0;
			code_length_d  = '0;
			line_started_d = 1'b0;
			run_is_gap_d   = 1'b0;
			run_count_d    = 4'd0;
		end
	end

	assign push         = accept && (n != 2'd0);
	assign bundle.cnt   = n;
	assign bundle.codes = codes;

	// Run and code state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q   <= 1'b0;
			run_count_q    <= 4'd0;
			run_is_gap_q   <= 1'b0;
			line_started_q <= 1'b0;
			code_pattern_q <= '0;
			code_length_q  <= '0;
		end else if (accept) begin
			prev_level_q   <= prev_level_d;
			run_count_q    <= run_count_d;
			run_is_gap_q   <= run_is_gap_d;
			line_started_q <= line_started_d;
			code_pattern_q <= code_pattern_d;
			code_length_q  <= code_length_d;
		end
	end

	`MRLD_ASSERT_IMPL(a_idle_line_clear, !line_started_q, run_count_q == 4'd0 && !run_is_gap_q)

endmodule

// File: src/mrld_queue.sv
// Short bundle queue between the front end and the output stage.
`timescale 1ns / 1ps
`include "morse_run_length_decoder_defines.svh"

module mrld_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mrld_pkg::bundle_t wr_data,
	input  logic              pop,
	output mrld_pkg::bundle_t head,
	output logic              full,
	output logic              empty
);
	import mrld_pkg::*;

	localparam int PTRW = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam logic [PTRW-1:0] PTR_LAST = PTRW'(DEPTH - 1);

	bundle_t         mem_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTRW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`MRLD_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
	`MRLD_ASSERT(a_no_overflow, !(push && full))
	`MRLD_ASSERT(a_no_underflow, !(pop && empty))

endmodule

// File: src/mrld_back.sv
// Output stage: walks each bundle and drives one character per beat.
`timescale 1ns / 1ps
`include "morse_run_length_decoder_defines.svh"

module mrld_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mrld_pkg::bundle_t head,
	input  logic              q_empty,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [6:0]        char_code,
	output logic              last_of_run
);
	import mrld_pkg::*;

	logic       result_valid_q;
	logic [6:0] char_code_q;
	logic       last_of_run_q;
	logic [1:0] idx_q;
	logic       load;
	logic       last;

	assign load = !result_valid_q || !result_stall;
	assign last = (idx_q == head.cnt - 2'd1);
	assign pop  = load && !q_empty && last;

	// Output register, refilled whenever the current beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			idx_q          <= 2'd0;
		end else if (load) begin
			result_valid_q <= !q_empty;
			if (!q_empty) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			char_code_q   <= head.codes[idx_q];
			last_of_run_q <= last;
		end
	end

	assign result_valid = result_valid_q;
	assign char_code    = char_code_q;
	assign last_of_run  = last_of_run_q;

	`MRLD_ASSERT_IMPL(a_idx_in_bundle, !q_empty, idx_q < head.cnt)

endmodule

// File: src/morse_run_length_decoder.sv
// A sample's characters are written into the bundle queue when the sample is accepted
// and then pass through the output register. One sample per cycle in; one character beat
// per cycle out while result_stall is low, one beat per character; the bundle queue absorbs bursts
// and the input stalls only while that queue is full.
// Reset: arst_n clears run, code and queue state at once and loads the registers with
// dash 3, letter gap 3, word gap 7; no clearing pass is needed.
`timescale 1ns / 1ps

module morse_run_length_decoder #(
	parameter int MAX_CODE_SYMBOLS = 4,
	parameter int QUEUE_DEPTH      = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_stall,
	input  logic       sample_level,
	input  logic       line_end,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [6:0] char_code,
	output logic       last_of_run,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);
	import mrld_pkg::*;

	cfg_t    cfg_q;
	bundle_t push_bundle;
	bundle_t head;
	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_empty;

	assign cfg_ready = 1'b1;

	// Timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dash_length       <= DASH_LENGTH_RST;
			cfg_q.letter_gap_length <= LETTER_GAP_RST;
			cfg_q.word_gap_length   <= WORD_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DASH_LENGTH: cfg_q.dash_length       <= cfg_data;
				CFG_LETTER_GAP:  cfg_q.letter_gap_length <= cfg_data;
				CFG_WORD_GAP:    cfg_q.word_gap_length   <= cfg_data;
				default: ;
			endcase
		end
	end

	mrld_front #(
		.MAX_CODE_SYMBOLS(MAX_CODE_SYMBOLS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_level (sample_level),
		.line_end     (line_end),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.push         (push),
		.bundle       (push_bundle)
	);

	mrld_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_bundle),
		.pop     (pop),
		.head    (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	mrld_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.char_code    (char_code),
		.last_of_run  (last_of_run)
	);

endmodule
